// File: hw/rtl/arpr_pkg.sv
// Package: shared constants, codes and types of the ARP resolver.
package arpr_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int PENDING_ENTRIES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 8;

  localparam logic [15:0] LIFETIME_RESET = 16'd30000;
  localparam logic [15:0] RETRY_RESET    = 16'd5000;

  localparam logic [15:0] ETH_TYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP    = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST  = 16'd1;
  localparam logic [47:0] MAC_BROADCAST   = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY    = 8'd3;

  typedef enum logic [2:0] {
    EM_NONE, EM_HIT, EM_REQ, EM_REPLY, EM_DELIVER, EM_DROP_NEW, EM_DROP_Q, EM_FLUSH
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PSCAN, S_EVICT_START, S_EVICT_RD, S_EVICT_EMIT, S_ALLOC,
    S_SEND_REQ, S_SEND_QUEUE, S_LEARN_SCAN, S_LEARN, S_REPLY, S_FLUSH_CHK,
    S_FLUSH_RD, S_FLUSH_EMIT, S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] hop_ip;
    logic [7:0]  datagram_id;
    logic [47:0] frame_dst_mac;
    logic [15:0] ether_type;
    logic        parse_ok;
    logic [15:0] arp_opcode;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip;
    logic [15:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [47:0] dst_mac;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [7:0]  out_datagram_id;
    logic        last;
  } result_t;

  typedef struct packed {
    logic  load;
    logic  tick;
    logic  cscan_start;
    logic  cscan_step;
    logic  learn;
    logic  pscan_start;
    logic  pscan_step;
    logic  p_latch;
    logic  k_clear;
    logic  k_inc;
    logic  q_read;
    logic  q_write;
    logic  p_alloc;
    logic  req_clear;
    logic  p_release;
    logic  finish_push;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic c_hit;
    logic c_free;
    logic p_hit;
    logic p_free;
    logic for_us;
    logic parse_ok;
    logic is_ipv4;
    logic is_arp;
    logic want_reply;
    logic need_req;
    logic q_full;
    logic k_done;
    logic cscan_last;
    logic pscan_last;
    logic can_push;
    logic hold_v;
  } status_t;

endpackage

// File: hw/rtl/arpr_if.sv
// Interfaces: input item, result and configuration channels.
interface arpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] hop_ip;
  logic [7:0]  datagram_id;
  logic [47:0] frame_dst_mac;
  logic [15:0] ether_type;
  logic        parse_ok;
  logic [15:0] arp_opcode;
  logic [31:0] arp_sender_ip;
  logic [47:0] arp_sender_mac;
  logic [31:0] arp_target_ip;
  logic [15:0] elapsed_ms;

  modport source (output valid, op, hop_ip, datagram_id, frame_dst_mac, ether_type,
                  parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac, arp_target_ip,
                  elapsed_ms, input ready);
  modport sink (input valid, op, hop_ip, datagram_id, frame_dst_mac, ether_type,
                parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac, arp_target_ip,
                elapsed_ms, output ready);
endinterface

interface arpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [47:0] dst_mac;
  logic [31:0] target_ip;
  logic [47:0] target_mac;
  logic [7:0]  out_datagram_id;
  logic        last;

  modport source (output valid, out_kind, dst_mac, target_ip, target_mac, out_datagram_id,
                  last, input ready);
  modport sink (input valid, out_kind, dst_mac, target_ip, target_mac, out_datagram_id,
                last, output ready);
endinterface

interface arpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/arp_resolver_with_pending_queue_unit.sv
// Top level: ARP resolver with per-address pending datagram queues.
// Channels: item (sink) takes one operation (send, receive, tick); result
// (source) returns zero or more result transactions per item, the final one
// carrying last; cfg (sink) writes own_mac, own_ip, cache lifetime and request
// retry time by index and is always ready; the user must write it only while
// no item is in progress, which the block does not enforce. One item is worked
// on at a time; item.ready is high only between items. A send that misses
// with a full pending table first scans it and evicts the queued handles of
// the entry with the largest request timer; an ARP frame with a full cache
// first scans the cache; eviction and flush take one queue RAM read and one
// push per handle. Results leave through an output register
// plus one held stage, so the first result shows one push after it is formed.
// When the result side stalls the controller waits at the next push; nothing
// is lost or repeated. Synchronous reset clears the cache and pending valid
// bits, the output stages and restores register defaults; no clearing pass.
module arp_resolver_with_pending_queue_unit import arpr_pkg::*; #(
  parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  arpr_in_if.sink   item,
  arpr_out_if.source result,
  arpr_cfg_if.sink  cfg
);
  cmd_t    cmd;
  status_t st;
  item_t   item_data;
  result_t res;

  assign item_data.op             = item.op;
  assign item_data.hop_ip         = item.hop_ip;
  assign item_data.datagram_id    = item.datagram_id;
  assign item_data.frame_dst_mac  = item.frame_dst_mac;
  assign item_data.ether_type     = item.ether_type;
  assign item_data.parse_ok       = item.parse_ok;
  assign item_data.arp_opcode     = item.arp_opcode;
  assign item_data.arp_sender_ip  = item.arp_sender_ip;
  assign item_data.arp_sender_mac = item.arp_sender_mac;
  assign item_data.arp_target_ip  = item.arp_target_ip;
  assign item_data.elapsed_ms     = item.elapsed_ms;

  assign cfg.ready = 1'b1;

  arpr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .st         (st),
    .cmd        (cmd)
  );

  arpr_datapath #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES),
    .QUEUE_DEPTH     (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item_data),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cmd          (cmd),
    .st           (st),
    .result       (res),
    .result_valid (result.valid),
    .result_ready (result.ready)
  );

  assign result.out_kind        = res.out_kind;
  assign result.dst_mac         = res.dst_mac;
  assign result.target_ip       = res.target_ip;
  assign result.target_mac      = res.target_mac;
  assign result.out_datagram_id = res.out_datagram_id;
  assign result.last            = res.last;
endmodule

// File: hw/rtl/arpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: hw/rtl/arpr_ctrl.sv
// Controller: sequences each operation through the datapath.
module arpr_ctrl import arpr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t st,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.emit   = EM_NONE;
    state_next = state;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.op)
          OP_SEND: begin
            if (st.c_hit) begin
              if (st.can_push) begin
                cmd.emit   = EM_HIT;
                state_next = S_FINISH;
              end
            end else if (st.p_hit) begin
              cmd.p_latch = 1'b1;
              state_next  = S_SEND_REQ;
            end else if (st.p_free) begin
              cmd.p_latch = 1'b1;
              state_next  = S_ALLOC;
            end else begin
              cmd.pscan_start = 1'b1;
              state_next      = S_PSCAN;
            end
          end
          OP_RECV: begin
            if (!st.for_us || !st.parse_ok) begin
              state_next = S_FINISH;
            end else if (st.is_ipv4) begin
              if (st.can_push) begin
                cmd.emit   = EM_DELIVER;
                state_next = S_FINISH;
              end
            end else if (st.is_arp) begin
              if (st.c_hit || st.c_free) begin
                state_next = S_LEARN;
              end else begin
                cmd.cscan_start = 1'b1;
                state_next      = S_LEARN_SCAN;
              end
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_TICK: begin
            cmd.tick   = 1'b1;
            state_next = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_PSCAN: begin
        cmd.pscan_step = 1'b1;
        if (st.pscan_last) state_next = S_EVICT_START;
      end
      S_EVICT_START: begin
        cmd.p_latch = 1'b1;
        cmd.k_clear = 1'b1;
        state_next  = S_EVICT_RD;
      end
      S_EVICT_RD: begin
        if (st.k_done) begin
          state_next = S_ALLOC;
        end else begin
          cmd.q_read = 1'b1;
          state_next = S_EVICT_EMIT;
        end
      end
      S_EVICT_EMIT: begin
        if (st.can_push) begin
          cmd.emit   = EM_DROP_Q;
          cmd.k_inc  = 1'b1;
          state_next = S_EVICT_RD;
        end
      end
      S_ALLOC: begin
        cmd.p_alloc = 1'b1;
        state_next  = S_SEND_REQ;
      end
      S_SEND_REQ: begin
        if (!st.need_req) begin
          state_next = S_SEND_QUEUE;
        end else if (st.can_push) begin
          cmd.emit      = EM_REQ;
          cmd.req_clear = 1'b1;
          state_next    = S_SEND_QUEUE;
        end
      end
      S_SEND_QUEUE: begin
        if (!st.q_full) begin
          cmd.q_write = 1'b1;
          state_next  = S_FINISH;
        end else if (st.can_push) begin
          cmd.emit   = EM_DROP_NEW;
          state_next = S_FINISH;
        end
      end
      S_LEARN_SCAN: begin
        cmd.cscan_step = 1'b1;
        if (st.cscan_last) state_next = S_LEARN;
      end
      S_LEARN: begin
        cmd.learn  = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (!st.want_reply) begin
          state_next = S_FLUSH_CHK;
        end else if (st.can_push) begin
          cmd.emit   = EM_REPLY;
          state_next = S_FLUSH_CHK;
        end
      end
      S_FLUSH_CHK: begin
        if (st.p_hit) begin
          cmd.p_latch = 1'b1;
          cmd.k_clear = 1'b1;
          state_next  = S_FLUSH_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FLUSH_RD: begin
        if (st.k_done) begin
          cmd.p_release = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.q_read = 1'b1;
          state_next = S_FLUSH_EMIT;
        end
      end
      S_FLUSH_EMIT: begin
        if (st.can_push) begin
          cmd.emit   = EM_FLUSH;
          cmd.k_inc  = 1'b1;
          state_next = S_FLUSH_RD;
        end
      end
      S_FINISH: begin
        if (!st.hold_v) begin
          state_next = S_IDLE;
        end else if (st.can_push) begin
          cmd.finish_push = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/arpr_datapath.sv
// Datapath: config registers, cache, pending table, queue RAM and result staging.
module arpr_datapath import arpr_pkg::*; #(
  parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data,
  input  cmd_t                 cmd,
  output status_t              st,
  output result_t              result,
  output logic                 result_valid,
  input  logic                 result_ready
);
  localparam int CW = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW = PENDING_ENTRIES > 1 ? $clog2(PENDING_ENTRIES) : 1;
  localparam int KW = $clog2(QUEUE_DEPTH + 1);
  localparam int QE = PENDING_ENTRIES * QUEUE_DEPTH;
  localparam int AW = QE > 1 ? $clog2(QE) : 1;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [15:0] lifetime;
  logic [15:0] retry;

  item_t it;

  logic        c_valid [CACHE_ENTRIES];
  logic [31:0] c_ip    [CACHE_ENTRIES];
  logic [47:0] c_mac   [CACHE_ENTRIES];
  logic [15:0] c_rem   [CACHE_ENTRIES];

  logic          p_valid [PENDING_ENTRIES];
  logic [31:0]   p_ip    [PENDING_ENTRIES];
  logic [15:0]   p_el    [PENDING_ENTRIES];
  logic [KW-1:0] p_cnt   [PENDING_ENTRIES];

  logic [CW-1:0] cs_idx, cs_best;
  logic [15:0]   cs_bval;
  logic [PW-1:0] p_reg, ps_best;
  logic [15:0]   ps_bval;
  logic [KW-1:0] k;
  logic          fresh;

  result_t hold, out_reg, em;
  logic    hold_v, out_v, out_free, can_push;

  logic [31:0]   key;
  logic          c_hit, c_free, p_hit, p_free;
  logic [CW-1:0] c_hit_idx, c_free_idx, learn_slot;
  logic [PW-1:0] p_hit_idx, p_free_idx, p_choice;
  logic [7:0]    q_rdata;
  logic [AW-1:0] q_base, q_raddr, q_waddr;

  assign key = (it.op == OP_SEND) ? it.hop_ip : it.arp_sender_ip;

  always_comb begin
    c_hit = 1'b0; c_hit_idx = '0; c_free = 1'b0; c_free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (c_valid[i] && c_ip[i] == key) begin
        c_hit = 1'b1; c_hit_idx = CW'(i);
      end
      if (!c_valid[i]) begin
        c_free = 1'b1; c_free_idx = CW'(i);
      end
    end
  end

  always_comb begin
    p_hit = 1'b0; p_hit_idx = '0; p_free = 1'b0; p_free_idx = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      if (p_valid[i] && p_ip[i] == key) begin
        p_hit = 1'b1; p_hit_idx = PW'(i);
      end
      if (!p_valid[i]) begin
        p_free = 1'b1; p_free_idx = PW'(i);
      end
    end
  end

  assign learn_slot = c_hit ? c_hit_idx : (c_free ? c_free_idx : cs_best);
  assign p_choice   = p_hit ? p_hit_idx : (p_free ? p_free_idx : ps_best);

  // queue storage is flattened: entry p, slot k at p*QUEUE_DEPTH + k
  assign q_base  = AW'(p_reg) * AW'(QUEUE_DEPTH);
  assign q_raddr = q_base + AW'(k);
  assign q_waddr = q_base + AW'(p_cnt[p_reg]);

  arpr_ram #(.WIDTH(8), .DEPTH(QE)) u_queue (
    .clk   (clk),
    .we    (cmd.q_write),
    .waddr (q_waddr),
    .wdata (it.datagram_id),
    .re    (cmd.q_read),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign out_free = !out_v || result_ready;
  assign can_push = !hold_v || out_free;

  always_comb begin
    em = '0;
    case (cmd.emit)
      EM_HIT: begin
        em.out_kind = KIND_FRAME; em.dst_mac = c_mac[c_hit_idx];
        em.out_datagram_id = it.datagram_id;
      end
      EM_REQ: begin
        em.out_kind = KIND_REQUEST; em.dst_mac = MAC_BROADCAST; em.target_ip = key;
      end
      EM_REPLY: begin
        em.out_kind = KIND_REPLY; em.dst_mac = it.arp_sender_mac;
        em.target_ip = it.arp_sender_ip; em.target_mac = it.arp_sender_mac;
      end
      EM_DELIVER: begin
        em.out_kind = KIND_DELIVER; em.out_datagram_id = it.datagram_id;
      end
      EM_DROP_NEW: begin
        em.out_kind = KIND_DROP; em.out_datagram_id = it.datagram_id;
      end
      EM_DROP_Q: begin
        em.out_kind = KIND_DROP; em.out_datagram_id = q_rdata;
      end
      EM_FLUSH: begin
        em.out_kind = KIND_FRAME; em.dst_mac = it.arp_sender_mac;
        em.out_datagram_id = q_rdata;
      end
      default: em = '0;
    endcase
  end

  // config and item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac  <= '0;
      own_ip   <= '0;
      lifetime <= LIFETIME_RESET;
      retry    <= RETRY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_MAC:  own_mac  <= cfg_data;
        REG_OWN_IP:   own_ip   <= cfg_data[31:0];
        REG_LIFETIME: lifetime <= cfg_data[15:0];
        REG_RETRY:    retry    <= cfg_data[15:0];
        default: ;
      endcase
    end
    if (cmd.load) it <= item;
  end

  // cache
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) c_valid[i] <= 1'b0;
    end else begin
      if (cmd.tick) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (c_valid[i]) begin
            if (c_rem[i] <= it.elapsed_ms) begin
              c_valid[i] <= 1'b0;
              c_rem[i]   <= '0;
            end else begin
              c_rem[i] <= c_rem[i] - it.elapsed_ms;
            end
          end
        end
      end
      if (cmd.learn) begin
        c_valid[learn_slot] <= 1'b1;
        c_ip[learn_slot]    <= it.arp_sender_ip;
        c_mac[learn_slot]   <= it.arp_sender_mac;
        c_rem[learn_slot]   <= lifetime;
      end
    end
    // least remaining lifetime, lowest index on ties
    if (cmd.cscan_start) begin
      cs_idx  <= '0;
      cs_best <= '0;
      cs_bval <= '1;
    end else if (cmd.cscan_step) begin
      if (c_rem[cs_idx] < cs_bval) begin
        cs_best <= cs_idx;
        cs_bval <= c_rem[cs_idx];
      end
      cs_idx <= cs_idx + 1'b1;
    end
  end

  // pending table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PENDING_ENTRIES; i++) begin
        p_valid[i] <= 1'b0;
        p_cnt[i]   <= '0;
      end
      fresh <= 1'b0;
    end else begin
      if (cmd.load) fresh <= 1'b0;
      if (cmd.tick) begin
        for (int i = 0; i < PENDING_ENTRIES; i++) begin
          if (p_valid[i]) begin
            p_el[i] <= (17'(p_el[i]) + 17'(it.elapsed_ms) > 17'hFFFF) ? 16'hFFFF
                       : p_el[i] + it.elapsed_ms;
          end
        end
      end
      if (cmd.p_alloc) begin
        p_valid[p_reg] <= 1'b1;
        p_ip[p_reg]    <= key;
        p_el[p_reg]    <= '0;
        p_cnt[p_reg]   <= '0;
        fresh          <= 1'b1;
      end
      if (cmd.req_clear) p_el[p_reg] <= '0;
      if (cmd.q_write) p_cnt[p_reg] <= p_cnt[p_reg] + 1'b1;
      if (cmd.p_release) begin
        p_valid[p_reg] <= 1'b0;
        p_cnt[p_reg]   <= '0;
        p_el[p_reg]    <= '0;
      end
    end
    // p_reg doubles as the scan index for the largest request timer
    if (cmd.pscan_start) begin
      p_reg   <= '0;
      ps_best <= '0;
      ps_bval <= '0;
    end else if (cmd.pscan_step) begin
      if (p_el[p_reg] > ps_bval) begin
        ps_best <= p_reg;
        ps_bval <= p_el[p_reg];
      end
      p_reg <= p_reg + 1'b1;
    end else if (cmd.p_latch) begin
      p_reg <= p_choice;
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
  end

  // one result held back so the final one can be marked last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_v  <= hold_v || (out_v && !result_ready);
      hold_v <= 1'b1;
    end else if (cmd.finish_push) begin
      out_v  <= 1'b1;
      hold_v <= 1'b0;
    end else if (out_v && result_ready) begin
      out_v <= 1'b0;
    end
    if (cmd.emit != EM_NONE) begin
      if (hold_v) out_reg <= hold;
      hold <= em;
    end else if (cmd.finish_push) begin
      out_reg <= {hold[$bits(result_t)-1:1], 1'b1};
    end
  end

  assign result       = out_reg;
  assign result_valid = out_v;

  always_comb begin
    st            = '0;
    st.op         = it.op;
    st.c_hit      = c_hit;
    st.c_free     = c_free;
    st.p_hit      = p_hit;
    st.p_free     = p_free;
    st.for_us     = (it.frame_dst_mac == own_mac) || (it.frame_dst_mac == MAC_BROADCAST);
    st.parse_ok   = it.parse_ok;
    st.is_ipv4    = it.ether_type == ETH_TYPE_IPV4;
    st.is_arp     = it.ether_type == ETH_TYPE_ARP;
    st.want_reply = (it.arp_opcode == ARP_OP_REQUEST) && (it.arp_target_ip == own_ip);
    st.need_req   = fresh || (p_el[p_reg] >= retry);
    st.q_full     = p_cnt[p_reg] == KW'(QUEUE_DEPTH);
    st.k_done     = k == p_cnt[p_reg];
    st.cscan_last = cs_idx == CW'(CACHE_ENTRIES - 1);
    st.pscan_last = p_reg == PW'(PENDING_ENTRIES - 1);
    st.can_push   = can_push;
    st.hold_v     = hold_v;
  end
endmodule
